[hw/rtl/swe_pkg.sv]
// Shared types and constants for the sliding window extreme block.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package swe_pkg;

  // Deque depth and field widths
  localparam int WINDOW_MAX = 64;
  localparam int SAMPLE_W   = 32;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;

  // Front search: cells are scanned in groups, one registered level holding every group's pick
  localparam int GROUP_SIZE = 8;
  localparam int GROUPS     = WINDOW_MAX / GROUP_SIZE;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SELECT_MIN  = 1'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // One cell's content as seen by its older neighbor
  typedef struct packed {
    logic    cand;
    sample_t value;
  } link_t;

  // Snapshot request from the cell row to the front search
  typedef struct packed {
    logic load;
    logic emit;
  } snap_t;

endpackage

`default_nettype wire

[hw/rtl/swe_cell.sv]
// One cell of the candidate row: holds the sample of one age and its candidate flag.
// Depends on swe_pkg.
`default_nettype none

module swe_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  logic            keep,
  input  logic            stop_in,
  input  logic            select_min,
  input  swe_pkg::sample_t sample,
  input  swe_pkg::link_t  prev,
  output swe_pkg::link_t  state,
  output logic            stop_out
);
  import swe_pkg::*;

  logic    cand;
  sample_t value;
  logic    live;
  logic    not_better;
  logic    kill;

  // Drop the incoming candidate when it left the window or a new sequence starts
  assign live = prev.cand & keep;

  // Compare against the new word; equal values count as not better
  assign not_better = select_min ? (prev.value >= sample) : (prev.value <= sample);

  // Pop only while every younger live candidate was popped too
  assign kill     = live & not_better & ~stop_in;
  assign stop_out = stop_in | (live & ~not_better);

  // Advance the flag one age per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      cand <= 1'b0;
    end else if (shift) begin
      cand <= live & ~kill;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (shift) begin
      value <= prev.value;
    end
  end

  assign state = '{cand: cand, value: value};

endmodule

`default_nettype wire

[hw/rtl/swe_front.sv]
// Front search and output register: picks the oldest candidate in two registered levels.
// Depends on swe_pkg.
`default_nettype none

module swe_front (
  input  logic                                        clk,
  input  logic                                        rst,
  input  swe_pkg::snap_t                              snap,
  input  logic [swe_pkg::WINDOW_MAX-1:0]              cand,
  input  swe_pkg::sample_t [swe_pkg::WINDOW_MAX-1:0]  value,
  output logic                                        can_load,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output swe_pkg::sample_t                            extreme
);
  import swe_pkg::*;

  logic                     grp_valid;
  logic                     grp_emit;
  logic [GROUPS-1:0]        grp_found;
  sample_t [GROUPS-1:0]     grp_value;
  logic [GROUPS-1:0]        pick_found;
  sample_t [GROUPS-1:0]     pick_value;
  sample_t                  front;
  logic                     grp_adv;

  // Oldest candidate inside each group: the highest index wins
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      pick_found[g] = 1'b0;
      pick_value[g] = value[g*GROUP_SIZE];
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (cand[g*GROUP_SIZE + j]) begin
          pick_found[g] = 1'b1;
          pick_value[g] = value[g*GROUP_SIZE + j];
        end
      end
    end
  end

  // Oldest group that holds a candidate
  always_comb begin
    front = grp_value[0];
    for (int g = 0; g < GROUPS; g++) begin
      if (grp_found[g]) begin
        front = grp_value[g];
      end
    end
  end

  // Group level moves on when it has nothing to emit or the output can take it
  assign grp_adv  = grp_valid & (~grp_emit | ~out_valid | out_ready);
  assign can_load = ~grp_valid | grp_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      grp_emit  <= 1'b0;
    end else if (snap.load) begin
      grp_valid <= 1'b1;
      grp_emit  <= snap.emit;
    end else if (grp_adv) begin
      grp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap.load) begin
      grp_found <= pick_found;
      grp_value <= pick_value;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (grp_adv & grp_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_adv & grp_emit) begin
      extreme <= front;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sliding_window_extreme.sv]
// Sliding window maximum or minimum over signed 32-bit words.
// Throughput: one word per cycle when not stalled; each cell shifts per accepted word.
// A result is registered in the cell row, the group search and the output register in
// turn, and is held there while the output is stalled.
// Reset: clears candidates, counters and pipeline valids at once, window size 1,
// maximum mode; no clearing pass. Depends on swe_pkg, swe_cell and swe_front.
`default_nettype none

module sliding_window_extreme (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [swe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [swe_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  swe_pkg::sample_t                    sample,
  input  logic                                first,
  output logic                                out_valid,
  input  logic                                out_ready,
  output swe_pkg::sample_t                    extreme
);
  import swe_pkg::*;

  logic [CFG_W-1:0]           window_size;
  logic                       select_min;
  logic [CFG_W-1:0]           win_eff;
  logic [CFG_W-1:0]           seen_count;
  logic [CFG_W-1:0]           seen_count_next;
  logic [CFG_W-1:0]           seen_base;
  logic                       pend;
  logic                       pend_emit;
  logic                       accept;
  logic                       can_load;
  snap_t                      snap;
  link_t [WINDOW_MAX-1:0]     cell_state;
  link_t [WINDOW_MAX-1:0]     cell_prev;
  logic  [WINDOW_MAX-1:0]     cell_keep;
  logic  [WINDOW_MAX-1:0]     stop_in;
  logic  [WINDOW_MAX-1:0]     stop_out;
  logic  [WINDOW_MAX-1:0]     cand;
  sample_t [WINDOW_MAX-1:0]   value;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= CFG_W'(1);
      select_min  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_SIZE: window_size <= cfg_data;
        REG_SELECT_MIN:  select_min  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the window into the supported range
  always_comb begin
    if (window_size == '0) begin
      win_eff = CFG_W'(1);
    end else if (window_size > CFG_W'(WINDOW_MAX)) begin
      win_eff = CFG_W'(WINDOW_MAX);
    end else begin
      win_eff = window_size;
    end
  end

  // Count words of the sequence, saturating at the window
  assign seen_base = first ? '0 : seen_count;
  always_comb begin
    if (seen_base + CFG_W'(1) < win_eff) begin
      seen_count_next = seen_base + CFG_W'(1);
    end else begin
      seen_count_next = win_eff;
    end
  end

  assign accept   = in_valid & in_ready;
  assign in_ready = ~pend | can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= '0;
    end else if (accept) begin
      seen_count <= seen_count_next;
    end
  end

  // Hold the row's result until the front search takes a snapshot
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      pend_emit <= 1'b0;
    end else if (accept) begin
      pend      <= 1'b1;
      pend_emit <= (seen_count_next >= win_eff);
    end else if (can_load) begin
      pend      <= 1'b0;
    end
  end

  assign snap = '{load: pend & can_load, emit: pend_emit};

  // Row of cells: cell k holds the word of age k; the new word enters cell 0
  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_prev[k] = '{cand: 1'b1, value: sample};
      assign cell_keep[k] = 1'b1;
      assign stop_in[k]   = 1'b1;
    end else begin : g_body
      assign cell_prev[k] = cell_state[k-1];
      assign cell_keep[k] = ~first & (CFG_W'(k) < win_eff);
      if (k == 1) begin : g_chain_start
        assign stop_in[k] = 1'b0;
      end else begin : g_chain
        assign stop_in[k] = stop_out[k-1];
      end
    end

    swe_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (accept),
      .keep      (cell_keep[k]),
      .stop_in   (stop_in[k]),
      .select_min(select_min),
      .sample    (sample),
      .prev      (cell_prev[k]),
      .state     (cell_state[k]),
      .stop_out  (stop_out[k])
    );

    assign cand[k]  = cell_state[k].cand;
    assign value[k] = cell_state[k].value;
  end

  swe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .snap     (snap),
    .cand     (cand),
    .value    (value),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .extreme  (extreme)
  );

  // The newest word is always a candidate
  assert property (@(posedge clk) disable iff (rst) accept |=> cand[0])
    else $error("newest word lost its candidate flag");

  // Input stalls only while a snapshot is pending
  assert property (@(posedge clk) disable iff (rst) !in_ready |-> pend)
    else $error("input stalled with nothing pending");

  // A pending snapshot stays until the front search takes it
  assert property (@(posedge clk) disable iff (rst) (pend && !can_load) |=> pend)
    else $error("pending snapshot dropped");

  // Reset leaves no pending work and no result
  assert property (@(posedge clk) rst |=> (!pend && !out_valid))
    else $error("pipeline not cleared by reset");

endmodule

`default_nettype wire
